>>> rtl/mrtc_pkg.sv
// Shared types, codes and helpers for the mixed-radix time counter.
`timescale 1ns / 1ps

package mrtc_pkg;

	localparam int DIGIT_W = 16;
	localparam int WIDE_W  = 32;
	localparam int RADIX_W = DIGIT_W + 1;
	localparam int DATA_W  = 3 * DIGIT_W + 2 * WIDE_W;

	// Last step of a three-step load sequence
	localparam logic [1:0] STEP_LAST = 2'd2;

	// Item kinds carried on tuser
	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_FIELDS = 2'd1,
		KIND_STAMP  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_e_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TPS    = 2'd0,
		REG_SPD    = 2'd1,
		REG_DPY    = 2'd2,
		REG_UNUSED = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} unit_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV
	} seq_state_t;

	// Command to the shared unit: MUL gives a * b + c, DIV gives a / b and a % b
	typedef struct packed {
		logic                 start;
		unit_op_t             op;
		logic [WIDE_W-1:0]    a;
		logic [RADIX_W-1:0]   b;
		logic [DIGIT_W-1:0]   c;
	} unit_cmd_t;

	typedef struct packed {
		logic                 done;
		logic [WIDE_W-1:0]    quo;
		logic [DIGIT_W-1:0]   rem;
	} unit_rsp_t;

	// Result item, tick in the lowest bits
	typedef struct packed {
		logic [WIDE_W-1:0]    stamp;
		logic [WIDE_W-1:0]    year;
		logic [DIGIT_W-1:0]   day;
		logic [DIGIT_W-1:0]   second;
		logic [DIGIT_W-1:0]   tick;
	} result_t;

	// A zero register means a full 16-bit digit
	function automatic logic [RADIX_W-1:0] radix_of(input logic [DIGIT_W-1:0] r);
		radix_of = (r == '0) ? {1'b1, {DIGIT_W{1'b0}}} : {1'b0, r};
	endfunction

endpackage

>>> rtl/mixed_radix_time_counter.sv
// Top level of the mixed-radix time counter: digits, sequencer and output buffer.
// Tick and unused-kind items: registered result, one per cycle while m_tready keeps up.
// Load-fields items: three passes through the shared multiplier rebuild the timestamp.
// Load-timestamp items: three 32-step divides in the shared unit.
// A two-entry output buffer lets one more item in while a result waits.
// Reset (arst_n low, asynchronous): digits, year and timestamp zero, radices one.
`timescale 1ns / 1ps

module mixed_radix_time_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// s_tdata fields from bit 0: year_in[32], day_in[16], second_in[16], tick_in[16],
	// timestamp_in[32]
	input  logic [mrtc_pkg::DATA_W-1:0] s_tdata,
	// s_tuser fields from bit 0: kind[2]
	input  logic [1:0]                  s_tuser,
	// Result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// m_tdata fields from bit 0: tick_out[16], second_out[16], day_out[16], year_out[32],
	// timestamp_out[32]
	output logic [mrtc_pkg::DATA_W-1:0] m_tdata,
	// Configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [15:0]                 cfg_data
);

	import mrtc_pkg::*;

	seq_state_t state_q, state_nx;

	logic [DIGIT_W-1:0] tps_q, spd_q, dpy_q;
	logic [RADIX_W-1:0] rt, rs, rd;

	logic [DIGIT_W-1:0] tick_q, second_q, day_q;
	logic [WIDE_W-1:0]  year_q, stamp_q;
	logic [1:0]         step_q;
	logic               launch_q;

	logic [WIDE_W-1:0]  year_in, stamp_in;
	logic [DIGIT_W-1:0] day_in, second_in, tick_in;
	kind_e_t            kind;
	logic               accept;

	unit_cmd_t cmd;
	unit_rsp_t rsp;

	// Tick carry chain
	logic [RADIX_W-1:0] t17, s17, d17;
	logic               c0, c1, c2;
	result_t            adv;

	// Result push and output buffer
	logic    push;
	result_t push_data;
	logic    last_done;
	result_t out_q, skid_q;
	logic    out_v_q, skid_v_q;
	logic    pop;

	// Unpack input fields
	assign year_in   = s_tdata[31:0];
	assign day_in    = s_tdata[47:32];
	assign second_in = s_tdata[63:48];
	assign tick_in   = s_tdata[79:64];
	assign stamp_in  = s_tdata[111:80];
	assign kind      = kind_e_t'(s_tuser);

	assign s_tready  = (state_q == ST_IDLE) && !skid_v_q;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign rt = radix_of(tps_q);
	assign rs = radix_of(spd_q);
	assign rd = radix_of(dpy_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= 16'd1;
			spd_q <= 16'd1;
			dpy_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TPS: tps_q <= cfg_data;
				REG_SPD: spd_q <= cfg_data;
				REG_DPY: dpy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance one tick, carrying through the digits on radix match
	always_comb begin
		t17 = {1'b0, tick_q} + RADIX_W'(1);
		c0  = (t17 == rt);
		s17 = {1'b0, second_q} + RADIX_W'(c0);
		c1  = (s17 == rs);
		d17 = {1'b0, day_q} + RADIX_W'(c1);
		c2  = (d17 == rd);
		adv.tick   = c0 ? '0 : t17[DIGIT_W-1:0];
		adv.second = c1 ? '0 : s17[DIGIT_W-1:0];
		adv.day    = c2 ? '0 : d17[DIGIT_W-1:0];
		adv.year   = year_q + WIDE_W'(c2);
		adv.stamp  = stamp_q + WIDE_W'(1);
	end

	mrtc_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	assign last_done = rsp.done && (step_q == STEP_LAST);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_FIELDS: state_nx = ST_MUL;
						KIND_STAMP:  state_nx = ST_DIV;
						default:     state_nx = ST_IDLE;
					endcase
				end
			end
			ST_MUL, ST_DIV: begin
				if (last_done) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs: unit command and result push
	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = OP_MUL;
		cmd.a     = '0;
		cmd.b     = '0;
		cmd.c     = '0;
		push      = 1'b0;
		push_data = '{stamp: stamp_q, year: year_q, day: day_q, second: second_q,
		              tick: tick_q};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_TICK: begin
							push      = 1'b1;
							push_data = adv;
						end
						KIND_NONE: push = 1'b1;
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				cmd.start = launch_q;
				cmd.op    = OP_MUL;
				case (step_q)
					2'd0: begin
						cmd.a = year_q;
						cmd.b = rd;
						cmd.c = day_q;
					end
					2'd1: begin
						cmd.a = rsp.quo;
						cmd.b = rs;
						cmd.c = second_q;
					end
					default: begin
						cmd.a = rsp.quo;
						cmd.b = rt;
						cmd.c = tick_q;
					end
				endcase
				if (last_done) begin
					push            = 1'b1;
					push_data.stamp = rsp.quo;
				end
			end
			ST_DIV: begin
				cmd.start = launch_q;
				cmd.op    = OP_DIV;
				case (step_q)
					2'd0: begin
						cmd.a = stamp_q;
						cmd.b = rt;
					end
					2'd1: begin
						cmd.a = rsp.quo;
						cmd.b = rs;
					end
					default: begin
						cmd.a = rsp.quo;
						cmd.b = rd;
					end
				endcase
				if (last_done) begin
					push           = 1'b1;
					push_data.day  = rsp.rem;
					push_data.year = rsp.quo;
				end
			end
			default: ;
		endcase
	end

	// Sequencer state, step count and launch flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			launch_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				step_q   <= '0;
				launch_q <= (kind == KIND_FIELDS) || (kind == KIND_STAMP);
			end else if (cmd.start) begin
				launch_q <= 1'b0;
			end else if (rsp.done && !last_done) begin
				step_q   <= step_q + 2'd1;
				launch_q <= 1'b1;
			end
		end
	end

	// Clock digits and timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			second_q <= '0;
			day_q    <= '0;
			year_q   <= '0;
			stamp_q  <= '0;
		end else if (accept) begin
			case (kind)
				KIND_TICK: begin
					tick_q   <= adv.tick;
					second_q <= adv.second;
					day_q    <= adv.day;
					year_q   <= adv.year;
					stamp_q  <= adv.stamp;
				end
				KIND_FIELDS: begin
					tick_q   <= tick_in;
					second_q <= second_in;
					day_q    <= day_in;
					year_q   <= year_in;
				end
				KIND_STAMP: stamp_q <= stamp_in;
				default: ;
			endcase
		end else if (rsp.done) begin
			if (state_q == ST_MUL) begin
				if (last_done) stamp_q <= rsp.quo;
			end else if (state_q == ST_DIV) begin
				case (step_q)
					2'd0: tick_q   <= rsp.rem;
					2'd1: second_q <= rsp.rem;
					default: begin
						day_q  <= rsp.rem;
						year_q <= rsp.quo;
					end
				endcase
			end
		end
	end

	// Two-entry output buffer: output register plus skid entry
	assign pop = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop || !out_v_q) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= push;
				end else begin
					out_v_q  <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else begin
				out_q  <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

>>> rtl/mrtc_unit.sv
// Shared multiply-add and bit-serial restoring divide unit.
`timescale 1ns / 1ps

module mrtc_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  mrtc_pkg::unit_cmd_t cmd,
	output mrtc_pkg::unit_rsp_t rsp
);

	import mrtc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic [WIDE_W-1:0]    quo_q;
	logic [RADIX_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   div_q;

	logic [WIDE_W+RADIX_W-1:0] prod;
	logic [WIDE_W-1:0]         mac;
	logic [RADIX_W:0]          trial;
	logic                      ge;
	logic [RADIX_W-1:0]        rem_nx;

	// Multiply-add, truncated to 32 bits
	always_comb begin
		prod = (WIDE_W+RADIX_W)'(cmd.a) * (WIDE_W+RADIX_W)'(cmd.b);
		mac  = prod[WIDE_W-1:0] + WIDE_W'(cmd.c);
	end

	// One restoring divide step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial  = {rem_q, quo_q[WIDE_W-1]};
		ge     = trial >= {1'b0, div_q};
		rem_nx = ge ? RADIX_W'(trial - {1'b0, div_q}) : trial[RADIX_W-1:0];
	end

	// Control: busy through 32 divide steps, done pulses one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q <= '0;
				if (cmd.op == OP_MUL) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.op == OP_MUL) begin
				quo_q <= mac;
			end else begin
				quo_q <= cmd.a;
				rem_q <= '0;
				div_q <= cmd.b;
			end
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDE_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q[DIGIT_W-1:0];

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the mixed-radix time counter: stream stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_top;
	import mrtc_pkg::*;

	// Longest item latency (load timestamp) with margin, used for the final quiet wait
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_REPORTS   = 40;

	// Input item as packed on s_tdata, year_in in the lowest bits
	typedef struct packed {
		logic [WIDE_W-1:0]  stamp_in;
		logic [DIGIT_W-1:0] tick_in;
		logic [DIGIT_W-1:0] second_in;
		logic [DIGIT_W-1:0] day_in;
		logic [WIDE_W-1:0]  year_in;
	} load_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata   = '0;
	logic [1:0]        s_tuser   = KIND_TICK;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = REG_TPS;
	logic [15:0]       cfg_data  = '0;

	// Predicted radix registers and clock state
	logic [DIGIT_W-1:0] ticks_per_sec;
	logic [DIGIT_W-1:0] secs_per_day;
	logic [DIGIT_W-1:0] days_in_year;
	logic [DIGIT_W-1:0] tick_d;
	logic [DIGIT_W-1:0] sec_d;
	logic [DIGIT_W-1:0] day_d;
	logic [WIDE_W-1:0]  year_c;
	logic [WIDE_W-1:0]  stamp_c;

	// Clock readings predicted but not yet seen on the result stream
	result_t pending_readings[$];

	int   src_idle_pct  = 0;
	int   sink_idle_pct = 0;
	logic sink_hold     = 1'b0;
	int   errors        = 0;
	int   readings_checked = 0;
	int   settings_used = 0;
	int   kind_count[4];

	always #1 clk = ~clk;

	mixed_radix_time_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Print one mismatch line (up to a cap) and count it
	task automatic report_mismatch(input string what, input logic [WIDE_W-1:0] got,
		input logic [WIDE_W-1:0] want);
		if (errors < MAX_REPORTS)
			$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [WIDE_W-1:0] got,
		input logic [WIDE_W-1:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	// A zero register stands for a full 16-bit digit
	function automatic logic [RADIX_W-1:0] full_radix(input logic [DIGIT_W-1:0] r);
		full_radix = (r == '0) ? 17'h10000 : {1'b0, r};
	endfunction

	// Add the incoming carry in 17 bits, clear on radix, hand the carry on
	task automatic carry_digit(inout logic [DIGIT_W-1:0] digit, input logic inc,
		input logic [DIGIT_W-1:0] r, output logic carry);
		logic [RADIX_W-1:0] sum;
		sum = {1'b0, digit} + {16'b0, inc};
		carry = (sum == full_radix(r));
		digit = carry ? '0 : sum[DIGIT_W-1:0];
	endtask

	// Advance the predicted clock by one accepted item and queue the reading
	task automatic clock_after_item(input kind_e_t k, input load_t ld);
		logic              c_tick;
		logic              c_sec;
		logic              c_day;
		logic [WIDE_W-1:0] acc;
		logic [WIDE_W-1:0] r;
		logic [WIDE_W-1:0] digit;
		result_t           reading;
		case (k)
		KIND_TICK: begin
			stamp_c = stamp_c + 32'd1;
			carry_digit(tick_d, 1'b1, ticks_per_sec, c_tick);
			carry_digit(sec_d, c_tick, secs_per_day, c_sec);
			carry_digit(day_d, c_sec, days_in_year, c_day);
			year_c = year_c + {31'b0, c_day};
		end
		KIND_FIELDS: begin
			year_c = ld.year_in;
			day_d  = ld.day_in;
			sec_d  = ld.second_in;
			tick_d = ld.tick_in;
			acc = {16'b0, ld.day_in} + ld.year_in * {15'b0, full_radix(days_in_year)};
			acc = {16'b0, ld.second_in} + {15'b0, full_radix(secs_per_day)} * acc;
			acc = {16'b0, ld.tick_in} + {15'b0, full_radix(ticks_per_sec)} * acc;
			stamp_c = acc;
		end
		KIND_STAMP: begin
			stamp_c = ld.stamp_in;
			acc = ld.stamp_in;
			r = {15'b0, full_radix(ticks_per_sec)};
			digit = acc % r;
			tick_d = digit[DIGIT_W-1:0];
			acc = acc / r;
			r = {15'b0, full_radix(secs_per_day)};
			digit = acc % r;
			sec_d = digit[DIGIT_W-1:0];
			acc = acc / r;
			r = {15'b0, full_radix(days_in_year)};
			digit = acc % r;
			day_d = digit[DIGIT_W-1:0];
			year_c = acc / r;
		end
		default: begin
			// unused kind leaves the clock as it is
		end
		endcase
		reading.tick   = tick_d;
		reading.second = sec_d;
		reading.day    = day_d;
		reading.year   = year_c;
		reading.stamp  = stamp_c;
		pending_readings.push_back(reading);
	endtask

	// Offer one item after random idle cycles; predict it once the transaction completes
	task automatic send_item(input kind_e_t k, input load_t ld);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= ld;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		clock_after_item(k, ld);
		kind_count[int'(k)]++;
	endtask

	// Drop valid and wait for every outstanding reading
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
		REG_TPS: ticks_per_sec = val;
		REG_SPD: secs_per_day  = val;
		REG_DPY: days_in_year  = val;
		default: begin
			// no register behind this index
		end
		endcase
		@(posedge clk);
	endtask

	// Reconfigure all three radices while the block is idle
	task automatic set_radices(input logic [15:0] t, input logic [15:0] s, input logic [15:0] d);
		drain();
		write_reg(REG_TPS, t);
		write_reg(REG_SPD, s);
		write_reg(REG_DPY, d);
		settings_used++;
	endtask

	function automatic logic [15:0] pick_radix();
		case ($urandom_range(6))
		0: pick_radix = 16'd1;
		1: pick_radix = 16'd2;
		2: pick_radix = 16'($urandom_range(10, 3));
		3: pick_radix = 16'hFFFF;
		4: pick_radix = 16'h0000;
		5: pick_radix = 16'hFFFE;
		default: pick_radix = 16'($urandom);
		endcase
	endfunction

	// Digit values near the radix, where the carry logic lives, plus zero, all ones, random
	function automatic logic [DIGIT_W-1:0] pick_digit(input logic [DIGIT_W-1:0] r);
		case ($urandom_range(5))
		0: pick_digit = '0;
		1: pick_digit = r - 16'd1;
		2: pick_digit = r;
		3: pick_digit = r + 16'd1;
		4: pick_digit = '1;
		default: pick_digit = 16'($urandom);
		endcase
	endfunction

	function automatic load_t rand_load();
		load_t ld;
		ld.tick_in   = pick_digit(ticks_per_sec);
		ld.second_in = pick_digit(secs_per_day);
		ld.day_in    = pick_digit(days_in_year);
		case ($urandom_range(2))
		0: ld.year_in = 32'hFFFF_FFFF - $urandom_range(3);
		1: ld.year_in = $urandom_range(3);
		default: ld.year_in = $urandom;
		endcase
		case ($urandom_range(3))
		0: ld.stamp_in = 32'hFFFF_FFFF - $urandom_range(3);
		1: ld.stamp_in = $urandom_range(100);
		default: ld.stamp_in = $urandom;
		endcase
		rand_load = ld;
	endfunction

	function automatic kind_e_t rand_kind();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			rand_kind = KIND_TICK;
		else if (r < 84)
			rand_kind = KIND_FIELDS;
		else if (r < 94)
			rand_kind = KIND_STAMP;
		else
			rand_kind = KIND_NONE;
	endfunction

	function automatic load_t make_load(input logic [31:0] y, input logic [15:0] d,
		input logic [15:0] s, input logic [15:0] t, input logic [31:0] ts);
		load_t ld;
		ld.year_in   = y;
		ld.day_in    = d;
		ld.second_in = s;
		ld.tick_in   = t;
		ld.stamp_in  = ts;
		make_load = ld;
	endfunction

	// Reset radices are all one, so every tick carries straight into the year
	task automatic test_reset_state();
		send_item(KIND_NONE, make_load('0, '0, '0, '0, '0));
		send_item(KIND_TICK, make_load('0, '0, '0, '0, '0));
		send_item(KIND_TICK, make_load('1, '1, '1, '1, '1));
	endtask

	// Small radices: carries, loads at and above the radix, timestamp wrap
	task automatic test_small_radices();
		set_radices(16'd3, 16'd2, 16'd2);
		write_reg(REG_UNUSED, 16'hFFFF);
		repeat (4) send_item(KIND_TICK, rand_load());
		send_item(KIND_FIELDS, make_load(32'd5, 16'd1, 16'd1, 16'd2, '0));
		send_item(KIND_TICK, rand_load());
		send_item(KIND_FIELDS, make_load(32'd7, 16'd2, 16'd2, 16'd3, '0));
		send_item(KIND_TICK, rand_load());
		send_item(KIND_FIELDS, make_load('0, '0, '0, 16'hFFFF, '0));
		send_item(KIND_TICK, rand_load());
		send_item(KIND_STAMP, make_load('0, '0, '0, '0, 32'hFFFF_FFFF));
		send_item(KIND_TICK, rand_load());
		send_item(KIND_NONE, rand_load());
	endtask

	// Zero registers (full 16-bit digits) and the largest radix
	task automatic test_wide_radices();
		set_radices(16'h0000, 16'h0000, 16'h0000);
		send_item(KIND_FIELDS, make_load('1, '1, '1, '1, '0));
		send_item(KIND_TICK, rand_load());
		send_item(KIND_STAMP, make_load('0, '0, '0, '0, 32'hFFFF_FFFF));
		send_item(KIND_TICK, rand_load());
		set_radices(16'hFFFF, 16'd1, 16'hFFFF);
		send_item(KIND_STAMP, make_load('0, '0, '0, '0, 32'h8000_0001));
		send_item(KIND_FIELDS, make_load(32'h8000_0000, 16'hFFFF, 16'd1, 16'hFFFF, '0));
		send_item(KIND_TICK, rand_load());
	endtask

	task automatic test_random(input int src_pct, input int sink_pct, input int settings,
		input int per_setting);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (settings) begin
			set_radices(pick_radix(), pick_radix(), pick_radix());
			repeat (per_setting)
				send_item(rand_kind(), rand_load());
		end
	endtask

	// Hold the result side off long enough that the block stalls its input
	task automatic test_backpressure();
		src_idle_pct = 0;
		fork
			begin
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
			end
		join_none
		repeat (30)
			send_item(rand_kind(), rand_load());
	endtask

	// Let the block empty completely between two bursts
	task automatic test_pause();
		repeat (10)
			send_item(rand_kind(), rand_load());
		drain();
		repeat (10)
			send_item(rand_kind(), rand_load());
	endtask

	// Result side: random stalls plus the long hold
	always @(posedge clk)
		m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);

	// Compare each completed result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_readings.size() == 0) begin
				report_mismatch("result with nothing outstanding", got.stamp, '0);
			end else begin
				want = pending_readings.pop_front();
				check_field("tick_out", got.tick, want.tick);
				check_field("second_out", got.second, want.second);
				check_field("day_out", got.day, want.day);
				check_field("year_out", got.year, want.year);
				check_field("timestamp_out", got.stamp, want.stamp);
				readings_checked++;
			end
		end
	end

	initial begin
		ticks_per_sec = 16'd1;
		secs_per_day  = 16'd1;
		days_in_year  = 16'd1;
		tick_d  = '0;
		sec_d   = '0;
		day_d   = '0;
		year_c  = '0;
		stamp_c = '0;
		foreach (kind_count[i])
			kind_count[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_small_radices();
		test_wide_radices();
		test_random(16, 84, 3, 110);
		test_random(84, 16, 3, 110);
		test_random(0, 0, 3, 110);
		test_backpressure();
		test_pause();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d radix settings; items: %0d tick, %0d load-fields,",
			settings_used, kind_count[0], kind_count[1]);
		$display("  %0d load-stamp, %0d unused kind; checked %0d results, %0d mismatches.",
			kind_count[2], kind_count[3], readings_checked, errors);
		if (errors == 0)
			$display("mixed_radix_time_counter test passed");
		else
			$display("mixed_radix_time_counter test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#1600000;
		$display("Timeout with %0d results outstanding.", pending_readings.size());
		$display("mixed_radix_time_counter test failed");
		$finish;
	end

endmodule
